/* hdl/dgf_pkg.sv */
// ----------------------------------------------------------------------------
// dgf_pkg
// Shared types, constants and helpers of the 3x3 dark gap filler.
// ----------------------------------------------------------------------------
package dgf_pkg;

    // default frame limits
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    // field and register widths
    localparam int SIZE_W     = 12;
    localparam int THR_W      = 8;
    localparam int CHAN_W     = 8;
    localparam int COORD_W    = 11;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 2;

    // smallest frame side that still has an interior pixel
    localparam int MIN_SIZE = 3;

    // register reset values
    localparam logic [SIZE_W-1:0] RESET_WIDTH     = 12'd640;
    localparam logic [SIZE_W-1:0] RESET_HEIGHT    = 12'd480;
    localparam logic [THR_W-1:0]  RESET_THRESHOLD = 8'd128;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH    = 2'd0,
        REG_IMAGE_HEIGHT   = 2'd1,
        REG_DARK_THRESHOLD = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    localparam int PIXEL_W = $bits(pixel_t);

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              frame_start;
    } in_item_t;

    typedef struct packed {
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
        logic [CHAN_W-1:0]  red_out;
        logic [CHAN_W-1:0]  green_out;
        logic [CHAN_W-1:0]  blue_out;
        logic               frame_last;
    } out_item_t;

    // what the position tracker tells the pipeline about one pixel
    typedef struct packed {
        logic               emit;
        logic               last;
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
    } pos_info_t;

    // a pixel is dark when any channel lies below the threshold
    function automatic logic is_dark(input pixel_t p, input logic [THR_W-1:0] thr);
        return (p.red < thr) || (p.green < thr) || (p.blue < thr);
    endfunction

endpackage

/* hdl/dgf_ram.sv */
// ----------------------------------------------------------------------------
// dgf_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// A read of the address written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module dgf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hdl/dgf_pos.sv */
// ----------------------------------------------------------------------------
// dgf_pos
// Raster position tracker: column and row of the pixel being accepted,
// interior test, end-of-frame flag and counter advance.
// ----------------------------------------------------------------------------
module dgf_pos #(
    parameter int MAX_WIDTH  = dgf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = dgf_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic                          frame_start,
    input  logic [dgf_pkg::SIZE_W-1:0]    image_width,
    input  logic [dgf_pkg::SIZE_W-1:0]    image_height,
    output logic [$clog2(MAX_WIDTH)-1:0]  col,
    output dgf_pkg::pos_info_t            info
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int WW = (XW + 1 > dgf_pkg::SIZE_W) ? XW + 1 : dgf_pkg::SIZE_W;
    localparam int HW = (YW + 1 > dgf_pkg::SIZE_W) ? YW + 1 : dgf_pkg::SIZE_W;

    logic [XW-1:0] col_reg, col_next;
    logic [YW-1:0] row_reg, row_next;
    logic [YW-1:0] row_cur;
    logic [WW-1:0] w_eff, col_ext, col_inc;
    logic [HW-1:0] h_eff, row_ext, row_inc;

    // effective frame size, clamped to the supported range
    always_comb
    begin
        priority if (image_width < dgf_pkg::SIZE_W'(dgf_pkg::MIN_SIZE))
            w_eff = WW'(dgf_pkg::MIN_SIZE);
        else if (WW'(image_width) > WW'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(image_width);

        priority if (image_height < dgf_pkg::SIZE_W'(dgf_pkg::MIN_SIZE))
            h_eff = HW'(dgf_pkg::MIN_SIZE);
        else if (HW'(image_height) > HW'(MAX_HEIGHT))
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(image_height);
    end

    // position of this pixel, frame start restarts at the origin
    assign col     = frame_start ? '0 : col_reg;
    assign row_cur = frame_start ? '0 : row_reg;
    assign col_ext = WW'(col);
    assign row_ext = HW'(row_cur);
    assign col_inc = col_ext + WW'(1);
    assign row_inc = row_ext + HW'(1);

    // interior test and last interior pixel
    always_comb
    begin
        info.emit  = (col_ext >= WW'(2)) && (row_ext >= HW'(2)) &&
                     (col_ext < w_eff) && (row_ext < h_eff);
        info.last  = (col_ext == w_eff - WW'(1)) && (row_ext == h_eff - HW'(1));
        info.out_x = dgf_pkg::COORD_W'(col_ext - WW'(1));
        info.out_y = dgf_pkg::COORD_W'(row_ext - HW'(1));
    end

    // counter advance with line and frame wrap
    always_comb
    begin
        if (col_inc >= w_eff)
        begin
            col_next = '0;
            row_next = (row_inc >= h_eff) ? '0 : YW'(row_inc);
        end
        else
        begin
            col_next = XW'(col_inc);
            row_next = row_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

/* hdl/dgf_window.sv */
// ----------------------------------------------------------------------------
// dgf_window
// 3x3 pixel window that shifts left by one column per pixel, with the
// dark-pair test around the centre pixel.
// ----------------------------------------------------------------------------
module dgf_window (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      shift,
    input  dgf_pkg::pixel_t           col_top,
    input  dgf_pkg::pixel_t           col_mid,
    input  dgf_pkg::pixel_t           col_bot,
    input  logic [dgf_pkg::THR_W-1:0] threshold,
    output dgf_pkg::pixel_t           centre,
    output logic                      fill
);

    // win_reg[row][col], row 0 is the top line
    dgf_pkg::pixel_t win_reg [3][3];

    logic tl, t, tr, l, r, bl, b, br;

    // shift in the newest column on the right
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
        end
        else if (shift)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= col_top;
            win_reg[1][2] <= col_mid;
            win_reg[2][2] <= col_bot;
        end
    end

    // darkness of the eight neighbours
    always_comb
    begin
        tl = dgf_pkg::is_dark(win_reg[0][0], threshold);
        t  = dgf_pkg::is_dark(win_reg[0][1], threshold);
        tr = dgf_pkg::is_dark(win_reg[0][2], threshold);
        l  = dgf_pkg::is_dark(win_reg[1][0], threshold);
        r  = dgf_pkg::is_dark(win_reg[1][2], threshold);
        bl = dgf_pkg::is_dark(win_reg[2][0], threshold);
        b  = dgf_pkg::is_dark(win_reg[2][1], threshold);
        br = dgf_pkg::is_dark(win_reg[2][2], threshold);
    end

    // opposite pairs and half-diagonal pairs
    assign fill = (l && r) || (t && b) || (tl && br) || (tr && bl) ||
                  (l && tr) || (l && br) || (tl && r) || (bl && r) ||
                  (t && bl) || (t && br) || (b && tl) || (b && tr);

    assign centre = win_reg[1][1];

endmodule

/* hdl/dark_gap_fill_3x3.sv */
// ----------------------------------------------------------------------------
// dark_gap_fill_3x3
// Streaming 3x3 dark gap filler for raster RGB pixels.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock while the output does not stall and
// gives one result per interior pixel; the pixel that completes a window
// passes the line store read, the window stage and the output register.
// The rate is set by the two line store RAMs, each read once and written
// once per pixel; a pixel that lands on the line store entry its predecessor
// is still writing gets that data forwarded. Border pixels give no beat.
// The line stores need no clearing after reset: the first two lines of a frame
// only feed border results. The user is to write configuration between frames
// while the pipeline is empty; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module dark_gap_fill_3x3 #(
    parameter int MAX_WIDTH  = dgf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = dgf_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [dgf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dgf_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  dgf_pkg::in_item_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output dgf_pkg::out_item_t                out_data
);

    localparam int XW = $clog2(MAX_WIDTH);

    // configuration registers
    logic [dgf_pkg::SIZE_W-1:0] width_reg, height_reg;
    logic [dgf_pkg::THR_W-1:0]  thr_reg;

    // pipeline control
    logic accept, s1_move, s2_free, out_free, fwd_hit;

    // position of the accepted pixel
    logic [XW-1:0]      pos_col;
    dgf_pkg::pos_info_t pos_info;
    dgf_pkg::pixel_t    in_pix;

    // stage 1: line store data arriving
    logic               s1_valid_reg;
    logic [XW-1:0]      s1_col_reg;
    dgf_pkg::pixel_t    s1_pix_reg;
    dgf_pkg::pos_info_t s1_info_reg;
    logic               s1_fwd_reg;
    dgf_pkg::pixel_t    s1_fwd_up_reg, s1_fwd_mid_reg;
    dgf_pkg::pixel_t    up_q, mid_q, s1_up, s1_mid;

    // stage 2: window complete
    logic               s2_valid_reg;
    dgf_pkg::pos_info_t s2_info_reg;
    dgf_pkg::pixel_t    centre;
    logic               fill;

    // output register
    logic               out_valid_reg;
    dgf_pkg::out_item_t out_data_reg;

    // configuration writes, unused index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= dgf_pkg::RESET_WIDTH;
            height_reg <= dgf_pkg::RESET_HEIGHT;
            thr_reg    <= dgf_pkg::RESET_THRESHOLD;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                dgf_pkg::REG_IMAGE_WIDTH:    width_reg  <= cfg_data;
                dgf_pkg::REG_IMAGE_HEIGHT:   height_reg <= cfg_data;
                dgf_pkg::REG_DARK_THRESHOLD: thr_reg    <= dgf_pkg::THR_W'(cfg_data);
                default:                     ;
            endcase
        end
    end

    // handshake and stage advance
    assign out_free = !out_valid_reg || out_ready;
    assign s2_free  = !s2_valid_reg || !s2_info_reg.emit || out_free;
    assign in_ready = !s1_valid_reg || s2_free;
    assign accept   = in_valid && in_ready;
    assign s1_move  = s1_valid_reg && s2_free;

    // same column written by the pixel ahead while this one reads it
    assign fwd_hit = s1_move && (s1_col_reg == pos_col);

    assign in_pix = '{red: in_data.red, green: in_data.green, blue: in_data.blue};

    dgf_pos #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_pos (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .frame_start  (in_data.frame_start),
        .image_width  (width_reg),
        .image_height (height_reg),
        .col          (pos_col),
        .info         (pos_info)
    );

    // line stores: upper takes the old middle, middle takes the new pixel
    dgf_ram #(
        .WIDTH (dgf_pkg::PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_ram_upper (
        .clk   (clk),
        .we    (s1_move),
        .waddr (s1_col_reg),
        .wdata (s1_mid),
        .re    (accept),
        .raddr (pos_col),
        .rdata (up_q)
    );

    dgf_ram #(
        .WIDTH (dgf_pkg::PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_ram_middle (
        .clk   (clk),
        .we    (s1_move),
        .waddr (s1_col_reg),
        .wdata (s1_pix_reg),
        .re    (accept),
        .raddr (pos_col),
        .rdata (mid_q)
    );

    // column data for the window, forwarded on a collision
    assign s1_up  = s1_fwd_reg ? s1_fwd_up_reg  : up_q;
    assign s1_mid = s1_fwd_reg ? s1_fwd_mid_reg : mid_q;

    // stage 1 registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg     <= pos_col;
            s1_pix_reg     <= in_pix;
            s1_info_reg    <= pos_info;
            s1_fwd_reg     <= fwd_hit;
            s1_fwd_up_reg  <= s1_mid;
            s1_fwd_mid_reg <= s1_pix_reg;
        end
    end

    dgf_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift     (s1_move),
        .col_top   (s1_up),
        .col_mid   (s1_mid),
        .col_bot   (s1_pix_reg),
        .threshold (thr_reg),
        .centre    (centre),
        .fill      (fill)
    );

    // stage 2 registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_free)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_info_reg <= s1_info_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s2_valid_reg && s2_info_reg.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s2_valid_reg && s2_info_reg.emit)
        begin
            out_data_reg.out_x      <= s2_info_reg.out_x;
            out_data_reg.out_y      <= s2_info_reg.out_y;
            out_data_reg.red_out    <= fill ? '0 : centre.red;
            out_data_reg.green_out  <= fill ? '0 : centre.green;
            out_data_reg.blue_out   <= fill ? '0 : centre.blue;
            out_data_reg.frame_last <= s2_info_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* hdl/dgf_checker.sv */
// ----------------------------------------------------------------------------
// dgf_checker
// Port-level checks of the dark gap filler, bound to the top level.
// ----------------------------------------------------------------------------
module dgf_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input dgf_pkg::out_item_t out_data
);

    // accepted pixels not yet matched by a result beat, sticky at the top
    logic [31:0] pending_reg;
    logic        in_beat, out_beat;

    assign in_beat  = in_valid && in_ready;
    assign out_beat = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (pending_reg != '1)
        begin
            pending_reg <= pending_reg + 32'(in_beat) - 32'(out_beat);
        end
    end

    // no result beat without an earlier pixel beat to cause it
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != '0)
        else $error("result beat with no pixel beat behind it");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result beat changed");

    // reset seen at an edge leaves the output empty by the next edge
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result beat during reset");

endmodule

bind dark_gap_fill_3x3 dgf_checker u_dgf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

/* dv/dark_gap_fill_3x3_test.sv */
// ----------------------------------------------------------------------------
// dark_gap_fill_3x3_test
// Self-checking bench for the streaming 3x3 dark gap filler. Raster pixels
// are pushed over the input channel with random gaps while the output side
// stalls at random. A cycle-free copy of the line stores and window predicts
// every interior result, and each output beat is compared field by field
// against the oldest prediction.
// ----------------------------------------------------------------------------
module dark_gap_fill_3x3_test;

    import dgf_pkg::*;

    localparam int CYCLE_LIMIT   = 5_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PIXELS = 1400;
    localparam int REPORT_LIMIT  = 10;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // three 3x3 frames: left/right pair dark, two dark corners that form no
    // pair, top with bottom-right dark; channel value 128 sits on the threshold
    localparam logic [PIXEL_W-1:0] DIRECTED_PIXELS [27] = '{
        24'hFFFFFF, 24'h808080, 24'hFFFFFF,
        24'h7FFFFF, 24'hAA55AA, 24'hFF7FFF,
        24'hFFFFFF, 24'h808080, 24'hFFFFFF,
        24'h000000, 24'hFFFFFF, 24'hFFFF00,
        24'hFFFFFF, 24'h55AA55, 24'hFFFFFF,
        24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
        24'hFFFFFF, 24'hFF00FF, 24'hFFFFFF,
        24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
        24'hFFFFFF, 24'hFFFFFF, 24'h0000FF
    };

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_data;

    // predictor copy of the registers and the pixel stores
    logic [SIZE_W-1:0] line_width   = RESET_WIDTH;
    logic [SIZE_W-1:0] frame_height = RESET_HEIGHT;
    logic [THR_W-1:0]  dark_level   = RESET_THRESHOLD;
    pixel_t            upper_line  [DEF_MAX_WIDTH];
    pixel_t            middle_line [DEF_MAX_WIDTH];
    pixel_t            win [9];
    int                col_pos = 0;
    int                row_pos = 0;
    out_item_t         filled_pixels_due [$];

    int        pixels_sent   = 0;
    int        results_seen  = 0;
    int        config_writes = 0;
    int        error_count   = 0;
    int        cycle_count   = 0;
    int        send_steady   = 0;
    int        stall_left    = 0;
    int        steady_left   = 0;
    out_item_t due;

    dark_gap_fill_3x3 dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, filled_pixels_due.size());
            $display("FAIL");
            $finish;
        end
    end

    // idle length: mostly none, some short, a few long
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 97)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int clamp_side(input int v, input int hi);
        if (v < MIN_SIZE)
            return MIN_SIZE;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic logic dark_pixel(input pixel_t p);
        return p.red < dark_level || p.green < dark_level || p.blue < dark_level;
    endfunction

    // any of the twelve opposite or half-diagonal pairs both dark
    function automatic logic window_has_gap();
        logic tl, t, tr, l, r, bl, b, br;
        tl = dark_pixel(win[0]);
        t  = dark_pixel(win[1]);
        tr = dark_pixel(win[2]);
        l  = dark_pixel(win[3]);
        r  = dark_pixel(win[5]);
        bl = dark_pixel(win[6]);
        b  = dark_pixel(win[7]);
        br = dark_pixel(win[8]);
        return (l && r) || (t && b) || (tl && br) || (tr && bl) ||
               (l && tr) || (l && br) || (tl && r) || (bl && r) ||
               (t && bl) || (t && br) || (b && tl) || (b && tr);
    endfunction

    // random pixel: mostly bright, some with one dark channel, some raw
    function automatic pixel_t random_pixel();
        pixel_t p;
        int     roll;
        roll = $urandom_range(0, 99);
        p = PIXEL_W'($urandom);
        if (roll >= 8)
        begin
            p.red   = CHAN_W'($urandom_range(dark_level, 255));
            p.green = CHAN_W'($urandom_range(dark_level, 255));
            p.blue  = CHAN_W'($urandom_range(dark_level, 255));
            if (dark_level > 0 && roll < 20)
            begin
                case ($urandom_range(0, 2))
                    0: p.red   = CHAN_W'($urandom_range(0, dark_level - 1));
                    1: p.green = CHAN_W'($urandom_range(0, dark_level - 1));
                    default: p.blue = CHAN_W'($urandom_range(0, dark_level - 1));
                endcase
            end
        end
        return p;
    endfunction

    function automatic void log_error(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    // advance the window by one accepted pixel and queue its result, if any
    task automatic predict_filled_pixel(input in_item_t item);
        pixel_t    px;
        pixel_t    centre;
        out_item_t res;
        int        x, y, w, h;
        w  = clamp_side(int'(line_width), DEF_MAX_WIDTH);
        h  = clamp_side(int'(frame_height), DEF_MAX_HEIGHT);
        px = {item.red, item.green, item.blue};
        if (item.frame_start)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        x = col_pos;
        y = row_pos;
        for (int r = 0; r < 3; r++)
        begin
            win[r * 3]     = win[r * 3 + 1];
            win[r * 3 + 1] = win[r * 3 + 2];
        end
        win[2] = upper_line[x];
        win[5] = middle_line[x];
        win[8] = px;
        upper_line[x]  = win[5];
        middle_line[x] = px;
        if (x >= 2 && y >= 2 && x < w && y < h)
        begin
            centre = window_has_gap() ? pixel_t'(0) : win[4];
            res.out_x      = COORD_W'(x - 1);
            res.out_y      = COORD_W'(y - 1);
            res.red_out    = centre.red;
            res.green_out  = centre.green;
            res.blue_out   = centre.blue;
            res.frame_last = (x == w - 1) && (y == h - 1);
            filled_pixels_due.push_back(res);
        end
        if (x + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (y + 1 >= h) ? 0 : y + 1;
        end
        else
            col_pos = x + 1;
    endtask

    // one input beat, after a random gap unless in a steady stretch
    task automatic send_pixel(input in_item_t item);
        int gap;
        if (send_steady > 0)
        begin
            send_steady--;
            gap = 0;
        end
        else
        begin
            if ($urandom_range(0, 199) == 0)
                send_steady = $urandom_range(50, 300);
            gap = idle_len();
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_filled_pixel(item);
        pixels_sent++;
    endtask

    // stop sending and wait out every due result plus the pipeline depth
    task automatic drain();
        in_valid <= 1'b0;
        while (filled_pixels_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:    line_width   = value;
            REG_IMAGE_HEIGHT:   frame_height = value;
            REG_DARK_THRESHOLD: dark_level   = value[THR_W-1:0];
            default: ;
        endcase
        config_writes++;
    endtask

    // random pixels; noisy runs add stray frame starts and full pauses
    task automatic send_run(input int count, input logic restart, input logic noisy);
        in_item_t item;
        for (int i = 0; i < count; i++)
        begin
            if (noisy && $urandom_range(0, 299) == 0)
                drain();
            item = {random_pixel(), restart && i == 0};
            if (noisy && $urandom_range(0, 249) == 0)
                item.frame_start = 1'b1;
            send_pixel(item);
        end
    endtask

    // sizes below the minimum, threshold boundary, frames back to back
    task automatic test_directed_frames();
        drain();
        write_reg(REG_IMAGE_WIDTH, 12'd0);
        write_reg(REG_IMAGE_HEIGHT, 12'd1);
        write_reg(REG_DARK_THRESHOLD, 12'd128);
        for (int i = 0; i < 27; i++)
            send_pixel({DIRECTED_PIXELS[i], i == 0});
    endtask

    // threshold zero makes nothing dark, 255 nearly everything
    task automatic test_threshold_extremes();
        drain();
        write_reg(REG_IMAGE_WIDTH, 12'd8);
        write_reg(REG_IMAGE_HEIGHT, 12'd5);
        write_reg(REG_DARK_THRESHOLD, 12'd0);
        send_run(40, 1'b1, 1'b0);
        drain();
        write_reg(REG_DARK_THRESHOLD, 12'd255);
        send_run(40, 1'b1, 1'b0);
    endtask

    // frame shrinks under the position counters, then an unused index write
    task automatic test_frame_shrink();
        drain();
        write_reg(REG_IMAGE_WIDTH, 12'd12);
        write_reg(REG_IMAGE_HEIGHT, 12'd10);
        write_reg(REG_DARK_THRESHOLD, 12'd128);
        // stop at row 4, column 9
        send_run(12 * 4 + 9, 1'b1, 1'b0);
        drain();
        write_reg(REG_IMAGE_WIDTH, 12'd5);
        // column 9 lies past the new line end, rows 5 to 7, then row 8 column 2
        send_run(1 + 5 * 3 + 2, 1'b0, 1'b0);
        drain();
        write_reg(REG_IMAGE_HEIGHT, 12'd4);
        write_reg(REG_UNUSED, 12'hFFF);
        // rest of row 8 lies below the frame, then two frames with no start
        send_run(3 + 5 * 4 * 2, 1'b0, 1'b0);
    endtask

    // random frame sizes and thresholds, whole frames with random content
    task automatic test_random_frames();
        int first, w, h, roll, n;
        first = pixels_sent;
        while (pixels_sent - first < RANDOM_PIXELS)
        begin
            drain();
            roll = $urandom_range(0, 99);
            if (roll < 5)
                w = $urandom_range(0, 2);
            else if (roll < 75)
                w = $urandom_range(3, 12);
            else if (roll < 95)
                w = $urandom_range(13, 40);
            else
                w = $urandom_range(41, 100);
            h = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
            roll = $urandom_range(0, 9);
            write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
            write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
            write_reg(REG_DARK_THRESHOLD,
                      CFG_DATA_W'(roll == 0 ? 0 : roll == 1 ? 255 : $urandom_range(1, 254)));
            n = clamp_side(w, DEF_MAX_WIDTH) * clamp_side(h, DEF_MAX_HEIGHT)
                * $urandom_range(1, 3) + $urandom_range(0, 5);
            send_run(n, 1'b1, 1'b1);
        end
    endtask

    // output ready: random stalls with occasional steady stretches
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            if (steady_left > 0)
                steady_left--;
            else if ($urandom_range(0, 199) == 0)
                steady_left = $urandom_range(50, 300);
            else
                stall_left = idle_len();
        end
    end

    task automatic check_field(input string field, input logic [11:0] want,
                               input logic [11:0] got);
        if (got !== want)
            log_error($sformatf("%s at x=%0d y=%0d: expected %0h, got %0h",
                                field, due.out_x, due.out_y, want, got));
    endtask

    // compare each output beat with the oldest due result
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (filled_pixels_due.size() == 0)
                log_error($sformatf("beat with no result due: x=%0d y=%0d",
                                    out_data.out_x, out_data.out_y));
            else
            begin
                due = filled_pixels_due.pop_front();
                check_field("out_x", 12'(due.out_x), 12'(out_data.out_x));
                check_field("out_y", 12'(due.out_y), 12'(out_data.out_y));
                check_field("red_out", 12'(due.red_out), 12'(out_data.red_out));
                check_field("green_out", 12'(due.green_out), 12'(out_data.green_out));
                check_field("blue_out", 12'(due.blue_out), 12'(out_data.blue_out));
                check_field("frame_last", 12'(due.frame_last), 12'(out_data.frame_last));
            end
        end
    end

    // test sequence
    initial
    begin
        foreach (upper_line[i])
        begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
        end
        foreach (win[i])
            win[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_frames();
        test_threshold_extremes();
        test_frame_shrink();
        test_random_frames();
        drain();

        $display("covered %0d pixels and %0d register writes: clamped and shrunk frames,",
                 pixels_sent, config_writes);
        $display("threshold extremes, random frames; %0d results checked, %0d bad",
                 results_seen, error_count);
        if (error_count == 0 && filled_pixels_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
